/* hw/rtl/chrn_pkg.sv */
// Shared types, codes and constants of the hash ring node load block.
package chrn_pkg;

    localparam int KEY_W        = 64;
    localparam int SLOT_W       = 11;
    localparam int NODE_W       = 6;
    localparam int WEIGHT_W     = 32;
    localparam int LOAD_W       = 48;
    localparam int CFG_W        = 12;
    localparam int CMD_W        = 2;
    localparam int NODE_SPAN    = 2 ** NODE_W;

    localparam int RING_DEPTH_DEF = 2048;
    localparam int MAX_NODES_DEF  = 64;

    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [KEY_W-1:0]    key_high;
        logic [KEY_W-1:0]    key_low;
        logic [SLOT_W-1:0]   entry_slot;
        logic [NODE_W-1:0]   node_select;
        logic [WEIGHT_W-1:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] owner_node;
        logic [LOAD_W-1:0] node_load_value;
        logic              wrapped;
        logic              load_saturated;
    } out_item_t;

    typedef struct packed {
        logic latch;
        logic srch_start;
        logic srch_step;
        logic ring_wr;
        logic ld_rd_item;
        logic ld_rd_found;
        logic commit;
        logic clr;
    } dp_ctrl_t;

    typedef struct packed {
        logic srch_done;
    } dp_stat_t;

endpackage

/* hw/rtl/chrn_ctrl.sv */
// Controller state machine sequencing ring writes, searches, load reads and updates, and clears.
module chrn_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [chrn_pkg::CMD_W-1:0]  in_cmd,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  chrn_pkg::dp_stat_t          stat,
    output chrn_pkg::dp_ctrl_t          ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_LDRD,
        S_SEARCH,
        S_OWN,
        S_COMMIT,
        S_CLEAR
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    always_comb
    begin
        state_next     = state_reg;
        ctrl           = '0;
        out_free       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.latch = 1'b1;
                    case (in_cmd)
                        chrn_pkg::CMD_WRITE:  state_next = S_WRITE;
                        chrn_pkg::CMD_LOOKUP:
                        begin
                            ctrl.srch_start = 1'b1;
                            state_next      = S_SEARCH;
                        end
                        chrn_pkg::CMD_READ:   state_next = S_LDRD;
                        default:              state_next = S_CLEAR;
                    endcase
                end
            end
            S_WRITE:
            begin
                ctrl.ring_wr = 1'b1;
                state_next   = S_LDRD;
            end
            S_LDRD:
            begin
                ctrl.ld_rd_item = 1'b1;
                state_next      = S_COMMIT;
            end
            S_SEARCH:
            begin
                ctrl.srch_step = 1'b1;
                if (stat.srch_done)
                begin
                    state_next = S_OWN;
                end
            end
            S_OWN:
            begin
                ctrl.ld_rd_found = 1'b1;
                state_next       = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    ctrl.commit    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                if (out_free)
                begin
                    ctrl.clr       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/chrn_datapath.sv */
// Datapath: ring memory, binary search registers, node load counters and result register.
module chrn_datapath #(
    parameter int RING_DEPTH = chrn_pkg::RING_DEPTH_DEF,
    parameter int MAX_NODES  = chrn_pkg::MAX_NODES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  chrn_pkg::in_item_t          in_data,
    input  logic [chrn_pkg::CFG_W-1:0]  entries_used,
    input  chrn_pkg::dp_ctrl_t          ctrl,
    output chrn_pkg::dp_stat_t          stat,
    output chrn_pkg::out_item_t         out_data
);

    localparam int RIDX_W     = $clog2(RING_DEPTH);
    localparam int BND_W      = $clog2(RING_DEPTH + 1);
    localparam int LOAD_DEPTH = (MAX_NODES < chrn_pkg::NODE_SPAN) ? MAX_NODES
                                                                  : chrn_pkg::NODE_SPAN;
    localparam int LIDX_W     = (LOAD_DEPTH > 1) ? $clog2(LOAD_DEPTH) : 1;
    localparam int SUM_W      = chrn_pkg::LOAD_W + 1;

    typedef struct packed {
        logic [chrn_pkg::KEY_W-1:0]  point_high;
        logic [chrn_pkg::KEY_W-1:0]  point_low;
        logic [chrn_pkg::NODE_W-1:0] owner;
    } ring_entry_t;

    chrn_pkg::in_item_t  item_reg;
    chrn_pkg::out_item_t out_reg;

    ring_entry_t         ring_mem [RING_DEPTH];
    ring_entry_t         ring_rd_reg;
    ring_entry_t         wr_entry;
    logic [RIDX_W-1:0]   ring_ra;
    logic [RIDX_W-1:0]   ring_wa;
    logic                ring_re;
    logic                slot_ok;

    logic [BND_W-1:0]    lo_reg, hi_reg, mid_reg;
    logic                wrap_reg;
    logic [BND_W-1:0]    n_ent, lo_n, hi_n, mid_n, span;
    logic                below, done, wrap_n;

    logic [chrn_pkg::LOAD_W-1:0] load_mem [LOAD_DEPTH];
    logic [chrn_pkg::LOAD_W-1:0] load_rd_reg;
    logic [LOAD_DEPTH-1:0]       load_vld_reg;
    logic [chrn_pkg::NODE_W-1:0] node_reg;
    logic                        nok_reg;
    logic                        lvld_reg;

    logic [chrn_pkg::NODE_W-1:0] ld_node;
    logic                        ld_re, ld_nok, ld_we;
    logic [LIDX_W-1:0]           ld_ra, ld_wa;
    logic [chrn_pkg::LOAD_W-1:0] cur_load, new_load, res_load;
    logic [SUM_W-1:0]            sum;
    logic                        is_lookup;

    // Clamp the entry count to one..depth.
    always_comb
    begin
        if (entries_used == '0)
        begin
            n_ent = BND_W'(1);
        end
        else if (32'(entries_used) > RING_DEPTH)
        begin
            n_ent = BND_W'(RING_DEPTH);
        end
        else
        begin
            n_ent = BND_W'(entries_used);
        end
    end

    always_comb
    begin
        below  = {ring_rd_reg.point_high, ring_rd_reg.point_low}
                 < {item_reg.key_high, item_reg.key_low};
        lo_n   = below ? (mid_reg + BND_W'(1)) : lo_reg;
        hi_n   = below ? hi_reg : mid_reg;
        span   = hi_n - lo_n;
        mid_n  = lo_n + (span >> 1);
        done   = (lo_n >= hi_n);
        wrap_n = (lo_n >= n_ent);
    end

    assign stat.srch_done = done;

    always_comb
    begin
        ring_re = ctrl.srch_start | ctrl.srch_step;
        if (ctrl.srch_start)
        begin
            ring_ra = RIDX_W'(n_ent >> 1);
        end
        else if (done)
        begin
            ring_ra = wrap_n ? '0 : lo_n[RIDX_W-1:0];
        end
        else
        begin
            ring_ra = mid_n[RIDX_W-1:0];
        end
        slot_ok             = 32'(item_reg.entry_slot) < RING_DEPTH;
        ring_wa             = RIDX_W'(item_reg.entry_slot);
        wr_entry.point_high = item_reg.key_high;
        wr_entry.point_low  = item_reg.key_low;
        wr_entry.owner      = item_reg.node_select;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ring_wr && slot_ok)
        begin
            ring_mem[ring_wa] <= wr_entry;
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[ring_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            item_reg <= in_data;
        end
        if (ctrl.srch_start)
        begin
            lo_reg  <= '0;
            hi_reg  <= n_ent;
            mid_reg <= n_ent >> 1;
        end
        else if (ctrl.srch_step)
        begin
            lo_reg   <= lo_n;
            hi_reg   <= hi_n;
            mid_reg  <= mid_n;
            wrap_reg <= wrap_n;
        end
    end

    always_comb
    begin
        ld_node   = ctrl.ld_rd_found ? ring_rd_reg.owner : item_reg.node_select;
        ld_re     = ctrl.ld_rd_item | ctrl.ld_rd_found;
        ld_nok    = 32'(ld_node) < MAX_NODES;
        ld_ra     = ld_node[LIDX_W-1:0];
        ld_wa     = node_reg[LIDX_W-1:0];
        is_lookup = (item_reg.cmd == chrn_pkg::CMD_LOOKUP);
        cur_load  = lvld_reg ? load_rd_reg : '0;
        sum       = SUM_W'(cur_load) + SUM_W'(item_reg.weight);
        new_load  = (sum >= SUM_W'(chrn_pkg::LOAD_MAX)) ? chrn_pkg::LOAD_MAX
                                                        : sum[chrn_pkg::LOAD_W-1:0];
        if (!nok_reg)
        begin
            res_load = '0;
        end
        else
        begin
            res_load = is_lookup ? new_load : cur_load;
        end
        ld_we     = ctrl.commit & is_lookup & nok_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            load_mem[ld_wa] <= new_load;
        end
        if (ld_re)
        begin
            load_rd_reg <= load_mem[ld_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_vld_reg <= '0;
        end
        else if (ctrl.clr)
        begin
            load_vld_reg <= '0;
        end
        else if (ld_we)
        begin
            load_vld_reg[ld_wa] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_re)
        begin
            node_reg <= ld_node;
            nok_reg  <= ld_nok;
            lvld_reg <= ld_nok && load_vld_reg[ld_ra];
        end
        if (ctrl.commit)
        begin
            out_reg.owner_node      <= node_reg;
            out_reg.node_load_value <= res_load;
            out_reg.wrapped         <= is_lookup & wrap_reg;
            out_reg.load_saturated  <= nok_reg && (res_load == chrn_pkg::LOAD_MAX);
        end
        else if (ctrl.clr)
        begin
            out_reg <= '0;
        end
    end

    assign out_data = out_reg;

endmodule

/* hw/rtl/consistent_hash_ring_node_load.sv */
// Top level of the hash ring lookup with per-node load counters.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata
//  in       | in_valid / in_ready    | in_data  (chrn_pkg::in_item_t)
//  out      | out_valid / out_ready  | out_data (chrn_pkg::out_item_t)
//
// One item is in work at a time; in_ready rises again at the edge where the result
// enters the output register. A lookup takes P probes of the binary search
// (floor(log2 n) or floor(log2 n)+1, twelve at most for 2048 entries), one probe
// per cycle on the ring memory read port. Reset clears the load counters at once through
// per-node valid bits; no sweep. A full output register stalls the final step until
// out_ready frees it.
module consistent_hash_ring_node_load #(
    parameter int RING_DEPTH = chrn_pkg::RING_DEPTH_DEF,
    parameter int MAX_NODES  = chrn_pkg::MAX_NODES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  chrn_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output chrn_pkg::out_item_t  out_data
);

    localparam logic REG_ENTRIES_USED = 1'b0;

    logic [chrn_pkg::CFG_W-1:0] used_reg, used_next;
    chrn_pkg::dp_ctrl_t         ctrl;
    chrn_pkg::dp_stat_t         stat;

    always_comb
    begin
        used_next = used_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_ENTRIES_USED))
        begin
            used_next = pwdata[chrn_pkg::CFG_W-1:0];
        end
        prdata = (paddr[2] == REG_ENTRIES_USED) ? 32'(used_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= chrn_pkg::CFG_W'(1);
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign pready = 1'b1;

    chrn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_data.cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    chrn_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_NODES  (MAX_NODES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_data      (in_data),
        .entries_used (used_reg),
        .ctrl         (ctrl),
        .stat         (stat),
        .out_data     (out_data)
    );

endmodule
